// File: sv/lprl_pkg.sv
package lprl_pkg;

    // Defaults for the top-level parameters.
    localparam int ROUTES_DEF = 16;
    localparam int PORTS_DEF  = 4;

    // Fixed field widths of the command and result ports.
    localparam int ADDR_W  = 32;
    localparam int INDEX_W = 4;
    localparam int PORT_W  = 2;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_REPORT
    } state_t;

    // One routing table entry as it sits in the table memory.
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] netmask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } entry_t;

    // Registered read response from the table.
    typedef struct packed {
        logic   vld;
        logic   mark;
        entry_t entry;
    } rd_t;

endpackage

// File: sv/lprl_table.sv
module lprl_table #(
    parameter int ROUTES = lprl_pkg::ROUTES_DEF,
    parameter int SLOT_W = $clog2(ROUTES)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [SLOT_W-1:0]  wr_slot,
    input  logic               wr_mark,
    input  lprl_pkg::entry_t   wr_entry,
    input  logic               rd_en,
    input  logic [SLOT_W-1:0]  rd_slot,
    output lprl_pkg::rd_t      rd
);

    lprl_pkg::entry_t mem [ROUTES];
    logic [ROUTES-1:0] mark_reg;
    lprl_pkg::entry_t  rd_entry_reg;
    logic              rd_mark_reg;
    logic              rd_vld_reg;

    // Entry fields live in a single-port-write, single-port-read memory.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_slot];
        end
    end

    // Valid marks are flip-flops so that reset empties the table at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg    <= '0;
            rd_mark_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                mark_reg[wr_slot] <= wr_mark;
            end
            rd_vld_reg <= rd_en;
            if (rd_en)
            begin
                rd_mark_reg <= mark_reg[rd_slot];
            end
        end
    end

    always_comb
    begin
        rd.vld   = rd_vld_reg;
        rd.mark  = rd_mark_reg;
        rd.entry = rd_entry_reg;
    end

endmodule

// File: sv/lprl_match.sv
module lprl_match #(
    parameter int SLOT_W = $clog2(lprl_pkg::ROUTES_DEF)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  lprl_pkg::rd_t                 rd,
    input  logic [SLOT_W-1:0]             rd_idx,
    input  logic [lprl_pkg::ADDR_W-1:0]   addr,
    output logic                          found,
    output logic [lprl_pkg::ADDR_W-1:0]   best_gateway,
    output logic [lprl_pkg::PORT_W-1:0]   best_port,
    output logic [SLOT_W-1:0]             best_idx
);

    logic                          hit_reg;
    logic [lprl_pkg::ADDR_W-1:0]   mask_reg;
    logic [lprl_pkg::ADDR_W-1:0]   gw_reg;
    logic [lprl_pkg::PORT_W-1:0]   port_reg;
    logic [SLOT_W-1:0]             idx_reg;
    logic                          is_match;
    logic                          take;

    // The shared compare unit: one masked equality test and one mask
    // magnitude compare per table entry. Strictly greater keeps the
    // earliest slot on a tie.
    always_comb
    begin
        is_match = rd.vld && rd.mark
                   && ((addr & rd.entry.netmask) == rd.entry.prefix);
        take     = is_match && (!hit_reg || (rd.entry.netmask > mask_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (clear)
        begin
            hit_reg <= 1'b0;
        end
        else if (take)
        begin
            hit_reg <= 1'b1;
        end
    end

    // Winner fields start at zero so that a miss reports zeros.
    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            mask_reg <= '0;
            gw_reg   <= '0;
            port_reg <= '0;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            mask_reg <= rd.entry.netmask;
            gw_reg   <= rd.entry.gateway;
            port_reg <= rd.entry.port;
            idx_reg  <= rd_idx;
        end
    end

    assign found        = hit_reg;
    assign best_gateway = gw_reg;
    assign best_port    = port_reg;
    assign best_idx     = idx_reg;

endmodule

// File: sv/longest_prefix_route_lookup.sv
// Channel   Direction  Transfer condition       Signals
// -------   ---------  -----------------------  ---------------------------------------
// command   in         start && !busy           cmd, entry_*, lookup_address
// result    out        done (one cycle strobe)  found, next_hop, out_port, matched_slot
//
// A write command updates one table slot in the cycle it is taken and keeps busy low.
// A lookup keeps busy high through the scan, which reads one table entry per cycle
// through the single memory read port into the one shared compare unit, a flush state
// that compares the last entry, and a report state with done.
// Reset empties the table by clearing every valid mark; it needs no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module longest_prefix_route_lookup #(
    parameter int ROUTES = lprl_pkg::ROUTES_DEF,
    parameter int PORTS  = lprl_pkg::PORTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [lprl_pkg::INDEX_W-1:0]  entry_index,
    input  logic                          entry_valid,
    input  logic [lprl_pkg::ADDR_W-1:0]   entry_prefix,
    input  logic [lprl_pkg::ADDR_W-1:0]   entry_netmask,
    input  logic [lprl_pkg::ADDR_W-1:0]   entry_gateway,
    input  logic [lprl_pkg::PORT_W-1:0]   entry_port,
    input  logic [lprl_pkg::ADDR_W-1:0]   lookup_address,
    output logic                          done,
    output logic                          found,
    output logic [lprl_pkg::ADDR_W-1:0]   next_hop,
    output logic [lprl_pkg::PORT_W-1:0]   out_port,
    output logic [lprl_pkg::INDEX_W-1:0]  matched_slot
);

    localparam int SLOT_W = $clog2(ROUTES);
    localparam int IW     = lprl_pkg::INDEX_W;
    localparam int PW     = lprl_pkg::PORT_W;

    lprl_pkg::state_t           state_reg;
    lprl_pkg::state_t           state_next;
    logic [SLOT_W-1:0]          cnt_reg;
    logic [SLOT_W-1:0]          rd_idx_reg;
    logic [lprl_pkg::ADDR_W-1:0] addr_reg;

    logic                       take_cmd;
    logic                       is_lookup;
    logic                       slot_ok;
    logic                       wr_en;
    logic [PW-1:0]              wr_port;
    lprl_pkg::entry_t           wr_entry;
    logic                       scan_last;
    logic                       rd_en;
    logic                       clear;
    lprl_pkg::rd_t              rd;
    logic [SLOT_W-1:0]          best_idx;

    // A command transfers whenever start meets an idle block.
    assign take_cmd  = start && !busy;
    assign is_lookup = (cmd == lprl_pkg::CMD_LOOKUP);

    // Writes to slots outside the table are dropped, and an interface
    // number beyond the last port is clamped to the last port.
    assign slot_ok = (32'(entry_index) < ROUTES);
    assign wr_en   = take_cmd && !is_lookup && slot_ok;

    always_comb
    begin
        if (32'(entry_port) >= PORTS)
        begin
            wr_port = PW'(PORTS - 1);
        end
        else
        begin
            wr_port = entry_port;
        end
        wr_entry.prefix  = entry_prefix;
        wr_entry.netmask = entry_netmask;
        wr_entry.gateway = entry_gateway;
        wr_entry.port    = wr_port;
    end

    assign scan_last = (cnt_reg == SLOT_W'(ROUTES - 1));

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lprl_pkg::ST_IDLE:
            begin
                if (take_cmd && is_lookup)
                begin
                    state_next = lprl_pkg::ST_SCAN;
                end
            end
            lprl_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = lprl_pkg::ST_FLUSH;
                end
            end
            lprl_pkg::ST_FLUSH:
            begin
                state_next = lprl_pkg::ST_REPORT;
            end
            lprl_pkg::ST_REPORT:
            begin
                state_next = lprl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lprl_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs. The scan issues one table read per cycle, and the
    // compare unit sees each entry in the cycle after its read.
    always_comb
    begin
        busy  = 1'b1;
        done  = 1'b0;
        rd_en = 1'b0;
        clear = 1'b0;
        case (state_reg)
            lprl_pkg::ST_IDLE:
            begin
                busy  = 1'b0;
                clear = take_cmd && is_lookup;
            end
            lprl_pkg::ST_SCAN:
            begin
                rd_en = 1'b1;
            end
            lprl_pkg::ST_FLUSH:
            begin
            end
            lprl_pkg::ST_REPORT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lprl_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear)
            begin
                cnt_reg <= '0;
            end
            else if (rd_en)
            begin
                cnt_reg <= cnt_reg + SLOT_W'(1);
            end
        end
    end

    // The address and the slot number of the entry in flight need no reset.
    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            addr_reg <= lookup_address;
        end
        if (rd_en)
        begin
            rd_idx_reg <= cnt_reg;
        end
    end

    lprl_table #(
        .ROUTES (ROUTES),
        .SLOT_W (SLOT_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_slot  (SLOT_W'(entry_index)),
        .wr_mark  (entry_valid),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_slot  (cnt_reg),
        .rd       (rd)
    );

    lprl_match #(
        .SLOT_W (SLOT_W)
    ) u_match (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (clear),
        .rd           (rd),
        .rd_idx       (rd_idx_reg),
        .addr         (addr_reg),
        .found        (found),
        .best_gateway (next_hop),
        .best_port    (out_port),
        .best_idx     (best_idx)
    );

    assign matched_slot = IW'(best_idx);

    // A result strobe is always followed by an idle block.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("result strobe not followed by idle");

    // A lookup transfer raises busy on the next cycle; a write does not.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take_cmd && is_lookup) |=> busy)
        else $error("lookup did not start a scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        (take_cmd && !is_lookup) |=> !busy && !done)
        else $error("write produced activity");

    // A miss reports all zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (next_hop == '0 && out_port == '0 && matched_slot == '0))
        else $error("miss with nonzero result fields");

    // Table reads happen only while the scan runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd.vld |-> (state_reg == lprl_pkg::ST_SCAN || state_reg == lprl_pkg::ST_FLUSH))
        else $error("table read outside a scan");

endmodule
